// ----- hw/rtl/mre_pkg.sv -----
package mre_pkg;

  // Request opcodes; the fourth code is rejected as a bad request
  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_RECV = 2'd1,
    OP_INT  = 2'd2,
    OP_RSVD = 2'd3
  } op_e;

  // Per-process mode
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SEND = 2'd1,
    MODE_RECV = 2'd2
  } mode_e;

  // Result status codes
  typedef enum logic [3:0] {
    STAT_SENT      = 4'd0,
    STAT_SEND_BLK  = 4'd1,
    STAT_RECVD     = 4'd2,
    STAT_RECV_BLK  = 4'd3,
    STAT_INT_TAKEN = 4'd4,
    STAT_INT_WOKE  = 4'd5,
    STAT_INT_PEND  = 4'd6,
    STAT_DEADLOCK  = 4'd7,
    STAT_BAD       = 4'd8
  } status_e;

  localparam logic [5:0] ID_ANY    = 6'd32;
  localparam logic [5:0] ID_INT    = 6'd33;
  localparam logic [5:0] LINK_NONE = 6'd63;

  // One row of the process table
  typedef struct packed {
    mode_e       mode;
    logic [5:0]  target;
    logic [5:0]  awaited;
    logic [31:0] buffer;
    logic        int_pend;
    logic [5:0]  head;
    logic [5:0]  tail;
    logic [5:0]  next_w;
  } rec_t;

  localparam rec_t REC_RESET = '{
    mode:     MODE_IDLE,
    target:   6'd0,
    awaited:  6'd0,
    buffer:   32'd0,
    int_pend: 1'b0,
    head:     LINK_NONE,
    tail:     LINK_NONE,
    next_w:   LINK_NONE
  };

  // One result word
  typedef struct packed {
    status_e     status;
    logic [5:0]  from_id;
    logic [4:0]  to_id;
    logic [31:0] from_buffer;
    logic [31:0] to_buffer;
    logic        wake_valid;
    logic [4:0]  wake_id;
    logic        caller_blocks;
  } res_t;

endpackage

// ----- hw/rtl/mre_req_if.sv -----
interface mre_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [4:0]  caller_id;
  logic [5:0]  peer_id;
  logic [31:0] buffer_handle;

  modport source (output valid, opcode, caller_id, peer_id, buffer_handle, input ready);
  modport sink   (input valid, opcode, caller_id, peer_id, buffer_handle, output ready);
endinterface

// ----- hw/rtl/mre_res_if.sv -----
interface mre_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [5:0]  from_id;
  logic [4:0]  to_id;
  logic [31:0] from_buffer;
  logic [31:0] to_buffer;
  logic        wake_valid;
  logic [4:0]  wake_id;
  logic        caller_blocks;

  modport source (output valid, status, from_id, to_id, from_buffer, to_buffer,
                  wake_valid, wake_id, caller_blocks, input ready);
  modport sink   (input valid, status, from_id, to_id, from_buffer, to_buffer,
                  wake_valid, wake_id, caller_blocks, output ready);
endinterface

// ----- hw/rtl/mre_table.sv -----
module mre_table #(
  parameter int NUM_PROCS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [$clog2(NUM_PROCS)-1:0] rd_addr_i,
  output mre_pkg::rec_t                rd_data_o,
  input  logic                         wr_en_i,
  input  logic [$clog2(NUM_PROCS)-1:0] wr_addr_i,
  input  mre_pkg::rec_t                wr_data_i
);

  mre_pkg::rec_t mem [NUM_PROCS];
  logic [NUM_PROCS-1:0] vld_q;
  mre_pkg::rec_t rd_q;
  logic rd_vld_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  // Track written rows; unwritten rows read as the reset row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : mre_pkg::REC_RESET;

endmodule

// ----- hw/rtl/message_rendezvous_engine_unit.sv -----
// Interrupt events pass through S_WAIT and S_CHK to S_DONE; requests with a bad
//   caller or opcode go straight to S_DONE. Send and receive time is set by the
//   chain walk or queue unlink through the single table read port.
// Throughput: one word at a time; ready again once the result is registered.
// Reset: all processes idle, queues empty, no interrupts pending, at once.
module message_rendezvous_engine_unit #(
  parameter int NUM_PROCS = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  mre_req_if.sink   req_i,
  mre_res_if.source res_o
);

  localparam int IDX_W = $clog2(NUM_PROCS);
  localparam int CNT_W = $clog2(NUM_PROCS + 1);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_WAIT  = 13'b0000000000010,
    S_CHK   = 13'b0000000000100,
    S_WALK  = 13'b0000000001000,
    S_DREC  = 13'b0000000010000,
    S_ENQT  = 13'b0000000100000,
    S_ENQD  = 13'b0000001000000,
    S_RSRC  = 13'b0000010000000,
    S_UNL   = 13'b0000100000000,
    S_WPREV = 13'b0001000000000,
    S_WC    = 13'b0010000000000,
    S_WFROM = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic [IDX_W-1:0] ra_q, ra_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [1:0]  op_q, op_d;
  logic [4:0]  c_q, c_d;
  logic [5:0]  peer_q, peer_d;
  logic [31:0] buf_q, buf_d;
  logic [5:0]  p_q, p_d, prev_q, prev_d, who_q, who_d, t_q, t_d;
  logic        found_q, found_d, link_q, link_d;
  mre_pkg::rec_t crec_q, crec_d, drec_q, drec_d, frec_q, frec_d, prec_q, prec_d;
  mre_pkg::res_t res_q, res_d, out_q;
  logic        ov_q, ov_d;

  mre_pkg::rec_t rdata, wr_data;
  logic [IDX_W-1:0] wr_addr;
  logic        wr_en;
  logic        load_out;

  function automatic logic id_ok(input logic [5:0] id);
    return 32'(id) < NUM_PROCS;
  endfunction

  function automatic logic [IDX_W-1:0] to_idx(input logic [5:0] id);
    return IDX_W'(id);
  endfunction

  function automatic mre_pkg::res_t mk_res(input mre_pkg::status_e st,
      input logic [5:0] from, input logic [4:0] to, input logic [31:0] fb,
      input logic [31:0] tb, input logic wv, input logic [4:0] wid,
      input logic blk);
    mre_pkg::res_t r;
    r.status        = st;
    r.from_id       = from;
    r.to_id         = to;
    r.from_buffer   = fb;
    r.to_buffer     = tb;
    r.wake_valid    = wv;
    r.wake_id       = wid;
    r.caller_blocks = blk;
    return r;
  endfunction

  mre_table #(.NUM_PROCS(NUM_PROCS)) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (ra_q),
    .rd_data_o (rdata),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign load_out    = (state_q == S_DONE) && (!ov_q || res_o.ready);

  // Sequencer
  always_comb begin
    mre_pkg::res_t bad;
    bad = mk_res(mre_pkg::STAT_BAD, 6'd0, 5'd0, 32'd0, 32'd0, 1'b0, 5'd0, 1'b0);
    state_d = state_q;
    ret_d   = ret_q;
    ra_d    = ra_q;
    n_d     = n_q;
    op_d    = op_q;
    c_d     = c_q;
    peer_d  = peer_q;
    buf_d   = buf_q;
    p_d     = p_q;
    prev_d  = prev_q;
    who_d   = who_q;
    t_d     = t_q;
    found_d = found_q;
    link_d  = link_q;
    crec_d  = crec_q;
    drec_d  = drec_q;
    frec_d  = frec_q;
    prec_d  = prec_q;
    res_d   = res_q;
    wr_en   = 1'b0;
    wr_addr = to_idx({1'b0, c_q});
    wr_data = crec_q;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d   = req_i.opcode;
          c_d    = req_i.caller_id;
          peer_d = req_i.peer_id;
          buf_d  = req_i.buffer_handle;
          if (!id_ok({1'b0, req_i.caller_id}) ||
              !(req_i.opcode inside {mre_pkg::OP_SEND, mre_pkg::OP_RECV,
                                     mre_pkg::OP_INT})) begin
            res_d   = bad;
            state_d = S_DONE;
          end else begin
            ra_d    = to_idx({1'b0, req_i.caller_id});
            ret_d   = S_CHK;
            state_d = S_WAIT;
          end
        end
      end

      S_WAIT: begin
        state_d = ret_q;
      end

      // Caller row is in hand: screen the request and dispatch
      S_CHK: begin
        crec_d  = rdata;
        state_d = S_DONE;
        case (op_q)
          mre_pkg::OP_SEND: begin
            if (!id_ok(peer_q) || peer_q == {1'b0, c_q} ||
                rdata.mode != mre_pkg::MODE_IDLE) begin
              res_d = bad;
            end else begin
              p_d     = peer_q;
              n_d     = '0;
              ra_d    = to_idx(peer_q);
              ret_d   = S_WALK;
              state_d = S_WAIT;
            end
          end
          mre_pkg::OP_RECV: begin
            if (rdata.mode != mre_pkg::MODE_IDLE || peer_q == {1'b0, c_q} ||
                (peer_q != mre_pkg::ID_ANY && peer_q != mre_pkg::ID_INT &&
                 !id_ok(peer_q))) begin
              res_d = bad;
            end else if (rdata.int_pend &&
                         (peer_q == mre_pkg::ID_ANY || peer_q == mre_pkg::ID_INT)) begin
              wr_en            = 1'b1;
              wr_data          = rdata;
              wr_data.int_pend = 1'b0;
              res_d = mk_res(mre_pkg::STAT_INT_TAKEN, mre_pkg::ID_INT, c_q, 32'd0,
                             buf_q, 1'b0, 5'd0, 1'b0);
            end else if (peer_q == mre_pkg::ID_ANY && id_ok(rdata.head)) begin
              who_d   = rdata.head;
              p_d     = rdata.head;
              prev_d  = mre_pkg::LINK_NONE;
              n_d     = '0;
              found_d = 1'b0;
              ra_d    = to_idx(rdata.head);
              ret_d   = S_UNL;
              state_d = S_WAIT;
            end else if (peer_q != mre_pkg::ID_ANY && id_ok(peer_q)) begin
              ra_d    = to_idx(peer_q);
              ret_d   = S_RSRC;
              state_d = S_WAIT;
            end else begin
              wr_en           = 1'b1;
              wr_data         = rdata;
              wr_data.mode    = mre_pkg::MODE_RECV;
              wr_data.awaited = peer_q;
              wr_data.buffer  = buf_q;
              res_d = mk_res(mre_pkg::STAT_RECV_BLK, 6'd0, 5'd0, 32'd0, 32'd0,
                             1'b0, 5'd0, 1'b1);
            end
          end
          mre_pkg::OP_INT: begin
            wr_en   = 1'b1;
            wr_data = rdata;
            if (rdata.mode == mre_pkg::MODE_RECV &&
                (rdata.awaited == mre_pkg::ID_INT || rdata.awaited == mre_pkg::ID_ANY)) begin
              wr_data.mode     = mre_pkg::MODE_IDLE;
              wr_data.awaited  = 6'd0;
              wr_data.int_pend = 1'b0;
              res_d = mk_res(mre_pkg::STAT_INT_WOKE, mre_pkg::ID_INT, c_q, 32'd0,
                             rdata.buffer, 1'b1, c_q, 1'b0);
            end else begin
              wr_data.int_pend = 1'b1;
              res_d = mk_res(mre_pkg::STAT_INT_PEND, 6'd0, 5'd0, 32'd0, 32'd0,
                             1'b0, 5'd0, 1'b0);
            end
          end
          default: begin
            res_d = bad;
          end
        endcase
      end

      // Follow send targets looking for a cycle back to the caller
      S_WALK: begin
        if (rdata.mode != mre_pkg::MODE_SEND) begin
          ra_d    = to_idx(peer_q);
          ret_d   = S_DREC;
          state_d = S_WAIT;
        end else if (rdata.target == {1'b0, c_q}) begin
          res_d = mk_res(mre_pkg::STAT_DEADLOCK, 6'd0, 5'd0, 32'd0, 32'd0,
                         1'b0, 5'd0, 1'b0);
          state_d = S_DONE;
        end else begin
          p_d     = rdata.target;
          n_d     = n_q + CNT_W'(1);
          state_d = S_WAIT;
          if (n_q == CNT_W'(NUM_PROCS - 1) || !id_ok(rdata.target)) begin
            ra_d  = to_idx(peer_q);
            ret_d = S_DREC;
          end else begin
            ra_d  = to_idx(rdata.target);
            ret_d = S_WALK;
          end
        end
      end

      // Destination row: deliver or queue the caller
      S_DREC: begin
        drec_d = rdata;
        if (rdata.mode == mre_pkg::MODE_RECV &&
            (rdata.awaited == {1'b0, c_q} || rdata.awaited == mre_pkg::ID_ANY)) begin
          wr_en           = 1'b1;
          wr_addr         = to_idx(peer_q);
          wr_data         = rdata;
          wr_data.mode    = mre_pkg::MODE_IDLE;
          wr_data.awaited = 6'd0;
          res_d = mk_res(mre_pkg::STAT_SENT, {1'b0, c_q}, 5'(peer_q), buf_q,
                         rdata.buffer, 1'b1, 5'(peer_q), 1'b0);
          state_d = S_DONE;
        end else begin
          wr_en          = 1'b1;
          wr_data        = crec_q;
          wr_data.mode   = mre_pkg::MODE_SEND;
          wr_data.target = peer_q;
          wr_data.buffer = buf_q;
          wr_data.next_w = mre_pkg::LINK_NONE;
          t_d            = rdata.tail;
          if (rdata.head == mre_pkg::LINK_NONE || !id_ok(rdata.tail)) begin
            link_d  = 1'b0;
            state_d = S_ENQD;
          end else begin
            link_d  = 1'b1;
            ra_d    = to_idx(rdata.tail);
            ret_d   = S_ENQT;
            state_d = S_WAIT;
          end
        end
      end

      // Link the caller behind the old tail
      S_ENQT: begin
        wr_en          = 1'b1;
        wr_addr        = to_idx(t_q);
        wr_data        = rdata;
        wr_data.next_w = {1'b0, c_q};
        state_d        = S_ENQD;
      end

      // Update the destination's queue pointers
      S_ENQD: begin
        wr_en        = 1'b1;
        wr_addr      = to_idx(peer_q);
        wr_data      = drec_q;
        wr_data.tail = {1'b0, c_q};
        if (!link_q) begin
          wr_data.head = {1'b0, c_q};
        end else if (t_q == peer_q) begin
          wr_data.next_w = {1'b0, c_q};
        end
        res_d = mk_res(mre_pkg::STAT_SEND_BLK, 6'd0, 5'd0, 32'd0, 32'd0,
                       1'b0, 5'd0, 1'b1);
        state_d = S_DONE;
      end

      // Named sender row: take it if it waits on the caller
      S_RSRC: begin
        if (rdata.mode == mre_pkg::MODE_SEND && rdata.target == {1'b0, c_q}) begin
          frec_d  = rdata;
          who_d   = peer_q;
          found_d = 1'b0;
          if (id_ok(crec_q.head)) begin
            p_d     = crec_q.head;
            prev_d  = mre_pkg::LINK_NONE;
            n_d     = '0;
            ra_d    = to_idx(crec_q.head);
            ret_d   = S_UNL;
            state_d = S_WAIT;
          end else begin
            state_d = S_WFROM;
          end
        end else begin
          wr_en           = 1'b1;
          wr_data         = crec_q;
          wr_data.mode    = mre_pkg::MODE_RECV;
          wr_data.awaited = peer_q;
          wr_data.buffer  = buf_q;
          res_d = mk_res(mre_pkg::STAT_RECV_BLK, 6'd0, 5'd0, 32'd0, 32'd0,
                         1'b0, 5'd0, 1'b1);
          state_d = S_DONE;
        end
      end

      // Search the caller's queue for the sender and splice it out
      S_UNL: begin
        if (p_q == who_q) begin
          found_d = 1'b1;
          frec_d  = rdata;
          if (!id_ok(prev_q)) begin
            crec_d.head = rdata.next_w;
          end
          if (crec_q.tail == p_q) begin
            crec_d.tail = prev_q;
          end
          prec_d.next_w = rdata.next_w;
          state_d       = S_WPREV;
        end else begin
          prev_d  = p_q;
          prec_d  = rdata;
          p_d     = rdata.next_w;
          n_d     = n_q + CNT_W'(1);
          if (n_q == CNT_W'(NUM_PROCS - 1) || !id_ok(rdata.next_w)) begin
            state_d = S_WFROM;
          end else begin
            ra_d    = to_idx(rdata.next_w);
            ret_d   = S_UNL;
            state_d = S_WAIT;
          end
        end
      end

      S_WPREV: begin
        if (id_ok(prev_q)) begin
          wr_en   = 1'b1;
          wr_addr = to_idx(prev_q);
          wr_data = prec_q;
        end
        state_d = S_WC;
      end

      S_WC: begin
        wr_en   = 1'b1;
        wr_data = crec_q;
        state_d = S_WFROM;
      end

      // Release the sender
      S_WFROM: begin
        wr_en          = 1'b1;
        wr_addr        = to_idx(who_q);
        wr_data        = frec_q;
        wr_data.mode   = mre_pkg::MODE_IDLE;
        wr_data.target = 6'd0;
        if (found_q) begin
          wr_data.next_w = mre_pkg::LINK_NONE;
        end
        res_d = mk_res(mre_pkg::STAT_RECVD, who_q, c_q, frec_q.buffer, buf_q,
                       1'b1, 5'(who_q), 1'b0);
        state_d = S_DONE;
      end

      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output word valid
  always_comb begin
    ov_d = ov_q && !res_o.ready;
    if (load_out) begin
      ov_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      ov_q    <= 1'b0;
      n_q     <= '0;
      ra_q    <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      ov_q    <= ov_d;
      n_q     <= n_d;
      ra_q    <= ra_d;
    end
  end

  // Working registers, no reset
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    c_q     <= c_d;
    peer_q  <= peer_d;
    buf_q   <= buf_d;
    p_q     <= p_d;
    prev_q  <= prev_d;
    who_q   <= who_d;
    t_q     <= t_d;
    found_q <= found_d;
    link_q  <= link_d;
    crec_q  <= crec_d;
    drec_q  <= drec_d;
    frec_q  <= frec_d;
    prec_q  <= prec_d;
    res_q   <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign res_o.valid         = ov_q;
  assign res_o.status        = out_q.status;
  assign res_o.from_id       = out_q.from_id;
  assign res_o.to_id         = out_q.to_id;
  assign res_o.from_buffer   = out_q.from_buffer;
  assign res_o.to_buffer     = out_q.to_buffer;
  assign res_o.wake_valid    = out_q.wake_valid;
  assign res_o.wake_id       = out_q.wake_id;
  assign res_o.caller_blocks = out_q.caller_blocks;

  // Checks
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE || state_q == S_WAIT) |-> !wr_en)
    else $error("table written outside a working state");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(n_q) < NUM_PROCS)
    else $error("walk counter ran past the table");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("accepted a second word while busy");

  a_block_no_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.caller_blocks && res_o.wake_valid))
    else $error("result both blocks the caller and wakes a process");

endmodule
